>>> rtl/core/pot_pkg.sv
package pot_pkg;

    localparam int NUM_WEIGHTS  = 8;
    localparam int FEATURE_BITS = 16;
    localparam int WEIGHT_BITS  = 32;
    localparam int NUM_FEATURES = 7;
    localparam int PROD_BITS    = FEATURE_BITS + WEIGHT_BITS;
    localparam int PAIR_BITS    = PROD_BITS + 1;
    localparam int NUM_PAIRS    = (NUM_WEIGHTS + 1) / 2;
    localparam int SUM_BITS     = PROD_BITS + $clog2(NUM_WEIGHTS) + 1;

    typedef logic signed [FEATURE_BITS-1:0] feat_t;
    typedef logic signed [WEIGHT_BITS-1:0]  weight_t;
    typedef logic signed [PROD_BITS-1:0]    prod_t;
    typedef logic signed [PAIR_BITS-1:0]    pair_t;
    typedef logic signed [SUM_BITS-1:0]     sum_t;

    localparam feat_t   BIAS_ONE = feat_t'(256);
    localparam weight_t W_MAX    = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam weight_t W_MIN    = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef struct packed {
        feat_t paddle_x;
        feat_t paddle_y;
        feat_t paddle_accel;
        feat_t ball_x;
        feat_t ball_y;
        feat_t ball_vel_x;
        feat_t ball_vel_y;
        logic  label_up;
        logic  label_down;
    } in_t;

    typedef struct packed {
        logic       predict_up;
        logic       predict_down;
        logic [1:0] updated;
        logic       saturated;
    } out_t;

    typedef struct packed {
        logic upd_up;
        logic add_up;
        logic upd_down;
        logic add_down;
    } lane_ctl_t;

    typedef struct packed {
        logic chg_up;
        logic chg_down;
        logic sat;
    } lane_flags_t;

    typedef struct packed {
        weight_t w;
        logic    sat;
    } wsat_t;

    // w +/- x, clipped to the weight range
    function automatic wsat_t weight_step(weight_t w, feat_t x, logic add);
        logic signed [WEIGHT_BITS:0] we;
        logic signed [WEIGHT_BITS:0] xe;
        logic signed [WEIGHT_BITS:0] s;
        wsat_t r;
        we = {w[WEIGHT_BITS-1], w};
        xe = {{(WEIGHT_BITS+1-FEATURE_BITS){x[FEATURE_BITS-1]}}, x};
        s  = add ? (we + xe) : (we - xe);
        if (s[WEIGHT_BITS] != s[WEIGHT_BITS-1])
        begin
            r.sat = 1'b1;
            r.w   = s[WEIGHT_BITS] ? W_MIN : W_MAX;
        end
        else
        begin
            r.sat = 1'b0;
            r.w   = s[WEIGHT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/pot_lane.sv
module pot_lane
    import pot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  feat_t       x,
    input  lane_ctl_t   ctl,
    output prod_t       prod_up,
    output prod_t       prod_down,
    output lane_flags_t flags
);

    weight_t w_up_reg;
    weight_t w_up_next;
    weight_t w_down_reg;
    weight_t w_down_next;
    prod_t   prod_up_reg;
    prod_t   prod_down_reg;
    prod_t   mul_up;
    prod_t   mul_down;
    wsat_t   step_up;
    wsat_t   step_down;

    assign mul_up   = prod_t'(w_up_reg) * prod_t'(x);
    assign mul_down = prod_t'(w_down_reg) * prod_t'(x);

    always_ff @(posedge clk)
    begin
        prod_up_reg   <= mul_up;
        prod_down_reg <= mul_down;
    end

    assign prod_up   = prod_up_reg;
    assign prod_down = prod_down_reg;

    always_comb
    begin
        step_up     = weight_step(w_up_reg, x, ctl.add_up);
        step_down   = weight_step(w_down_reg, x, ctl.add_down);
        w_up_next   = ctl.upd_up ? step_up.w : w_up_reg;
        w_down_next = ctl.upd_down ? step_down.w : w_down_reg;
        flags.chg_up   = w_up_next != w_up_reg;
        flags.chg_down = w_down_next != w_down_reg;
        flags.sat      = (ctl.upd_up && step_up.sat) || (ctl.upd_down && step_down.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_up_reg   <= '0;
            w_down_reg <= '0;
        end
        else
        begin
            w_up_reg   <= w_up_next;
            w_down_reg <= w_down_next;
        end
    end

endmodule

>>> rtl/core/pot_merge.sv
module pot_merge
    import pot_pkg::*;
(
    input  logic  clk,
    input  prod_t prod_up   [NUM_WEIGHTS],
    input  prod_t prod_down [NUM_WEIGHTS],
    output logic  pred_up,
    output logic  pred_down
);

    pair_t pair_up_reg   [NUM_PAIRS];
    pair_t pair_down_reg [NUM_PAIRS];
    pair_t pair_up       [NUM_PAIRS];
    pair_t pair_down     [NUM_PAIRS];
    sum_t  sum_up;
    sum_t  sum_down;
    logic  pred_up_reg;
    logic  pred_down_reg;

    for (genvar k = 0; k < NUM_PAIRS; k++)
    begin : g_pair
        if (2 * k + 1 < NUM_WEIGHTS)
        begin : g_two
            assign pair_up[k]   = PAIR_BITS'(prod_up[2*k]) + PAIR_BITS'(prod_up[2*k+1]);
            assign pair_down[k] = PAIR_BITS'(prod_down[2*k]) + PAIR_BITS'(prod_down[2*k+1]);
        end
        else
        begin : g_one
            assign pair_up[k]   = PAIR_BITS'(prod_up[2*k]);
            assign pair_down[k] = PAIR_BITS'(prod_down[2*k]);
        end
    end

    always_ff @(posedge clk)
    begin
        pair_up_reg   <= pair_up;
        pair_down_reg <= pair_down;
    end

    always_comb
    begin
        sum_up   = '0;
        sum_down = '0;
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            sum_up   = sum_up + SUM_BITS'(pair_up_reg[k]);
            sum_down = sum_down + SUM_BITS'(pair_down_reg[k]);
        end
    end

    // sum of zero counts as +1
    always_ff @(posedge clk)
    begin
        pred_up_reg   <= ~sum_up[SUM_BITS-1];
        pred_down_reg <= ~sum_down[SUM_BITS-1];
    end

    assign pred_up   = pred_up_reg;
    assign pred_down = pred_down_reg;

endmodule

>>> rtl/core/perceptron_online_trainer_top.sv
// Online trainer for two sign-activated perceptrons (up key, down key).
// Input channel: in_valid / in_stall / in_data, one training sample per transfer.
// Output channel: out_valid / out_stall / out_data, one result per sample,
// holding both predictions taken before the update plus update flags.
// Config: cfg_we / cfg_wdata write train_mask; write only while idle.
// Stages: one lane per weight multiplies, the pairs are added, then the
// final add and sign, then weights update and the result is registered.
// Only one sample is in the pipeline at a time, set by the weight feedback
// loop: the next sample enters on the same edge the weights update.
// A result may wait in the output register while the next sample is worked;
// if it is still not taken when the next one finishes, that sample holds in
// the last stage and in_stall stays high until the output drains.
// Reset clears all weights to zero, train_mask to 3 and empties the pipeline.
module perceptron_online_trainer_top
    import pot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        v4_next;
    logic        accept;
    logic        fire;
    logic [1:0]  mask_reg;
    in_t         item_reg;
    out_t        out_reg;
    logic        out_valid_reg;
    out_t        result;
    feat_t       feat  [NUM_FEATURES];
    feat_t       x_vec [NUM_WEIGHTS];
    prod_t       prod_up   [NUM_WEIGHTS];
    prod_t       prod_down [NUM_WEIGHTS];
    lane_flags_t flags     [NUM_WEIGHTS];
    lane_ctl_t   ctl;
    logic        pred_up;
    logic        pred_down;
    logic        any_up, any_down, any_sat;

    assign fire     = v4_reg && (!out_valid_reg || !out_stall);
    assign in_stall = v1_reg || v2_reg || v3_reg || (v4_reg && !fire);
    assign accept   = in_valid && !in_stall;
    assign v4_next  = v3_reg || (v4_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            mask_reg <= 2'b11;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v4_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign feat[0] = item_reg.paddle_x;
    assign feat[1] = item_reg.paddle_y;
    assign feat[2] = item_reg.paddle_accel;
    assign feat[3] = item_reg.ball_x;
    assign feat[4] = item_reg.ball_y;
    assign feat[5] = item_reg.ball_vel_x;
    assign feat[6] = item_reg.ball_vel_y;

    assign ctl.upd_up   = fire && mask_reg[0] && (pred_up != item_reg.label_up);
    assign ctl.add_up   = item_reg.label_up;
    assign ctl.upd_down = fire && mask_reg[1] && (pred_down != item_reg.label_down);
    assign ctl.add_down = item_reg.label_down;

    for (genvar i = 0; i < NUM_WEIGHTS; i++)
    begin : g_lane
        if (i == 0)
        begin : g_bias
            assign x_vec[i] = BIAS_ONE;
        end
        else if (i <= NUM_FEATURES)
        begin : g_feat
            assign x_vec[i] = feat[i-1];
        end
        else
        begin : g_zero
            assign x_vec[i] = '0;
        end

        pot_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .x         (x_vec[i]),
            .ctl       (ctl),
            .prod_up   (prod_up[i]),
            .prod_down (prod_down[i]),
            .flags     (flags[i])
        );
    end

    pot_merge u_merge (
        .clk       (clk),
        .prod_up   (prod_up),
        .prod_down (prod_down),
        .pred_up   (pred_up),
        .pred_down (pred_down)
    );

    always_comb
    begin
        any_up   = 1'b0;
        any_down = 1'b0;
        any_sat  = 1'b0;
        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            any_up   = any_up | flags[i].chg_up;
            any_down = any_down | flags[i].chg_down;
            any_sat  = any_sat | flags[i].sat;
        end
        result.predict_up   = pred_up;
        result.predict_down = pred_down;
        result.updated      = {any_down, any_up};
        result.saturated    = any_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({v1_reg, v2_reg, v3_reg, v4_reg}))
        else $error("more than one sample in flight");

    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(v1_reg || v2_reg || v3_reg))
        else $error("sample accepted while pipeline busy");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |=> v3_reg ##1 v4_reg)
        else $error("pipeline stage dropped");

    a_mask_up: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !mask_reg[0]) |-> !result.updated[0])
        else $error("up weights changed while disabled");

    a_mask_down: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !mask_reg[1]) |-> !result.updated[1])
        else $error("down weights changed while disabled");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pot_pkg::*;

    localparam int    PHASES      = 7;
    localparam int    PHASE_ITEMS = 165;
    localparam int    HOLD_CYCLES = 300;
    localparam int    LATENCY     = 4;
    localparam feat_t FEAT_HI     = feat_t'(16'h7fff);
    localparam feat_t FEAT_LO     = feat_t'(16'h8000);

    class perceptron_twin;
        longint      weights[2][NUM_WEIGHTS];
        logic [1:0]  train_mask;
        out_t        predictions_due[$];
        int unsigned n_err;
        int unsigned n_taken;
        int unsigned n_checked;
        int unsigned n_flat;
        int unsigned n_upd[2];

        function new();
            foreach (weights[p, i])
                weights[p][i] = 0;
            train_mask = 2'b11;
            n_err      = 0;
            n_taken    = 0;
            n_checked  = 0;
            n_flat     = 0;
            n_upd[0]   = 0;
            n_upd[1]   = 0;
        endfunction

        function bit sum_sign(int p, longint x[NUM_WEIGHTS]);
            longint acc;
            acc = 0;
            for (int i = 0; i < NUM_WEIGHTS; i++)
                acc += weights[p][i] * x[i];
            if (acc == 0)
                n_flat++;
            return (acc >= 0);
        endfunction

        function void adjust(int p, longint x[NUM_WEIGHTS], bit add,
                             output bit changed, output bit clipped);
            longint nxt;
            changed = 1'b0;
            clipped = 1'b0;
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                nxt = add ? weights[p][i] + x[i] : weights[p][i] - x[i];
                if (nxt > longint'(W_MAX))
                begin
                    nxt     = longint'(W_MAX);
                    clipped = 1'b1;
                end
                if (nxt < longint'(W_MIN))
                begin
                    nxt     = longint'(W_MIN);
                    clipped = 1'b1;
                end
                if (nxt != weights[p][i])
                    changed = 1'b1;
                weights[p][i] = nxt;
            end
        endfunction

        function void take_sample(in_t s);
            longint   x[NUM_WEIGHTS];
            bit [1:0] lab;
            bit [1:0] pred;
            bit       chg;
            bit       clip;
            out_t     e;
            x[0] = longint'(BIAS_ONE);
            x[1] = longint'($signed(s.paddle_x));
            x[2] = longint'($signed(s.paddle_y));
            x[3] = longint'($signed(s.paddle_accel));
            x[4] = longint'($signed(s.ball_x));
            x[5] = longint'($signed(s.ball_y));
            x[6] = longint'($signed(s.ball_vel_x));
            x[7] = longint'($signed(s.ball_vel_y));
            for (int i = NUM_FEATURES + 1; i < NUM_WEIGHTS; i++)
                x[i] = 0;
            lab = {s.label_down, s.label_up};
            e   = '0;
            for (int p = 0; p < 2; p++)
                pred[p] = sum_sign(p, x);
            for (int p = 0; p < 2; p++)
            begin
                if (train_mask[p] && pred[p] != lab[p])
                begin
                    adjust(p, x, lab[p], chg, clip);
                    if (chg)
                    begin
                        e.updated[p] = 1'b1;
                        n_upd[p]++;
                    end
                    if (clip)
                        e.saturated = 1'b1;
                end
            end
            e.predict_up   = pred[0];
            e.predict_down = pred[1];
            predictions_due = {predictions_due, e};
            n_taken++;
        endfunction

        function void check_result(out_t r);
            out_t e;
            if (predictions_due.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %h", r);
                n_err++;
                return;
            end
            e = predictions_due.pop_front();
            n_checked++;
            if (r.predict_up !== e.predict_up)
            begin
                $error("predict_up: expected %0d, got %0d", e.predict_up, r.predict_up);
                n_err++;
            end
            if (r.predict_down !== e.predict_down)
            begin
                $error("predict_down: expected %0d, got %0d", e.predict_down, r.predict_down);
                n_err++;
            end
            if (r.updated !== e.updated)
            begin
                $error("updated: expected %0d, got %0d", e.updated, r.updated);
                n_err++;
            end
            if (r.saturated !== e.saturated)
            begin
                $error("saturated: expected %0d, got %0d", e.saturated, r.saturated);
                n_err++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = 2'b00;

    perceptron_twin twin = new();
    bit             hold_req = 1'b0;
    bit             quiet_tx = 1'b0;
    bit             quiet_rx = 1'b0;
    int unsigned    n_mask_writes = 0;

    perceptron_online_trainer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            twin.check_result(out_data);

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic feat_t draw_feature();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return feat_t'($urandom);
        if (r < 85)
            return feat_t'($urandom_range(0, 1023)) - feat_t'(512);
        case ($urandom_range(0, 2))
            0:       return FEAT_LO;
            1:       return FEAT_HI;
            default: return '0;
        endcase
    endfunction

    function automatic in_t make_sample(feat_t f[NUM_FEATURES], logic lu, logic ld);
        return {f[0], f[1], f[2], f[3], f[4], f[5], f[6], lu, ld};
    endfunction

    // mostly a learnable rule: press up when the ball is above the paddle
    function automatic in_t draw_sample();
        in_t s;
        s.paddle_x     = draw_feature();
        s.paddle_y     = draw_feature();
        s.paddle_accel = draw_feature();
        s.ball_x       = draw_feature();
        s.ball_y       = draw_feature();
        s.ball_vel_x   = draw_feature();
        s.ball_vel_y   = draw_feature();
        if ($urandom_range(0, 99) < 65)
        begin
            s.label_up   = ($signed(s.ball_y) > $signed(s.paddle_y));
            s.label_down = ($signed(s.ball_y) < $signed(s.paddle_y));
        end
        else
        begin
            {s.label_up, s.label_down} = 2'($urandom);
        end
        return s;
    endfunction

    task automatic send_sample(input in_t s);
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        twin.take_sample(s);
    endtask

    task automatic idle_tx();
        int unsigned n;
        n = quiet_tx ? 0 : pick_gap();
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (twin.predictions_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic load_mask(input logic [1:0] m);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        twin.train_mask = m;
        n_mask_writes++;
    endtask

    // output side backpressure
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet_rx)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        feat_t       f[NUM_FEATURES];
        logic [1:0]  mask_plan[PHASES];
        int unsigned waited;

        mask_plan[0] = 2'b11;
        mask_plan[1] = 2'b00;
        mask_plan[2] = 2'b01;
        mask_plan[3] = 2'b10;
        mask_plan[4] = 2'($urandom);
        mask_plan[5] = 2'($urandom);
        mask_plan[6] = 2'b11;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bias only: zero sum right after reset
        foreach (f[i]) f[i] = '0;
        send_sample(make_sample(f, 1'b0, 1'b0));
        send_sample(make_sample(f, 1'b1, 1'b1));
        idle_tx();
        foreach (f[i]) f[i] = FEAT_HI;
        send_sample(make_sample(f, 1'b1, 1'b0));
        foreach (f[i]) f[i] = FEAT_LO;
        send_sample(make_sample(f, 1'b0, 1'b1));
        for (int k = 0; k < NUM_FEATURES; k++)
        begin
            foreach (f[i]) f[i] = (i == k) ? FEAT_LO : FEAT_HI;
            send_sample(make_sample(f, k[0], k[1]));
            idle_tx();
        end
        foreach (f[i]) f[i] = '0;
        send_sample(make_sample(f, 1'b1, 1'b0));

        // each perceptron frozen in turn
        load_mask(2'b00);
        send_sample(draw_sample());
        send_sample(draw_sample());
        load_mask(2'b01);
        send_sample(draw_sample());
        send_sample(draw_sample());
        load_mask(2'b10);
        send_sample(draw_sample());
        send_sample(draw_sample());

        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_mask(mask_plan[phase]);
            quiet_tx = (phase == 1 || phase == 5);
            quiet_rx = (phase == 2 || phase == 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 3 && k == 40)
                    hold_req = 1'b1;
                if ((phase == 4 && k == 60) || $urandom_range(0, 199) == 0)
                    settle();
                send_sample(draw_sample());
                idle_tx();
            end
        end

        in_valid <= 1'b0;
        quiet_rx = 1'b0;
        waited   = 0;
        while (twin.predictions_due.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge clk);
        if (twin.predictions_due.size() != 0)
        begin
            $error("%0d expected results never arrived", twin.predictions_due.size());
            twin.n_err++;
        end

        $display("trained on %0d samples, checked %0d results over %0d train_mask writes",
                 twin.n_taken, twin.n_checked, n_mask_writes);
        $display("weights moved %0d times (up) and %0d times (down); %0d zero-sum predictions",
                 twin.n_upd[0], twin.n_upd[1], twin.n_flat);
        if (twin.n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> perceptron_online_trainer_top.f
rtl/core/pot_pkg.sv
rtl/core/pot_lane.sv
rtl/core/pot_merge.sv
rtl/core/perceptron_online_trainer_top.sv
bench/tb.sv
